@@ design/rthv_pkg.sv @@
// Shared types and constants for the RGB to hue and value converter.
// No dependencies; every other design file imports this package.
`default_nettype none

package rthv_pkg;

  // Width of one hue sector and the fraction scale.
  localparam int unsigned HUE_SECTOR = 65537;
  localparam int unsigned FRAC_SHIFT = 16;

  localparam int unsigned CHAN_W = 8;
  localparam int unsigned HUE_W  = 19;
  localparam int unsigned SEC_W  = 3;
  // Quotient holds the integer bit plus FRAC_SHIFT fraction bits.
  localparam int unsigned QUO_W  = FRAC_SHIFT + 1;

  // Quotient bits resolved by the first and by the later divider stages.
  localparam int unsigned DIV_STEPS_LEAD = 5;
  localparam int unsigned DIV_STEPS      = 4;

  // Sector codes, in tie-break order.
  typedef enum logic [SEC_W-1:0] {
    SEC_R_B = 3'd0,
    SEC_G_B = 3'd1,
    SEC_G_R = 3'd2,
    SEC_B_R = 3'd3,
    SEC_B_G = 3'd4,
    SEC_R_G = 3'd5
  } sector_t;

  // Pixel beat as it enters the pipeline.
  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              tag;
  } pixel_t;

  // Working beat carried through the divider stages.
  typedef struct packed {
    logic [CHAN_W-1:0] value;
    sector_t           sector;
    logic              gray;
    logic              tag;
    logic [CHAN_W-1:0] divisor;
    logic [CHAN_W-1:0] rem;
    logic [QUO_W-1:0]  quo;
  } work_t;

  // Finished result beat.
  typedef struct packed {
    logic [CHAN_W-1:0] value;
    logic [HUE_W-1:0]  hue;
    logic              tag;
  } result_t;

endpackage

`default_nettype wire

@@ design/rthv_sort.sv @@
// First pipeline stage: finds max, min and mid channel, picks the sector
// and sets up the divider operands. Depends on rthv_pkg.
`default_nettype none

module rthv_sort (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  rthv_pkg::pixel_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output rthv_pkg::work_t out_data
);
  import rthv_pkg::*;

  logic [CHAN_W-1:0] mx;
  logic [CHAN_W-1:0] mn;
  logic [CHAN_W+1:0] sum;
  logic [CHAN_W+1:0] mid_wide;
  logic [CHAN_W-1:0] mid;
  sector_t           sec;
  work_t             data_next;

  // Largest and smallest channel.
  always_comb begin
    mx = in_data.red;
    if (in_data.green > mx) mx = in_data.green;
    if (in_data.blue > mx) mx = in_data.blue;
    mn = in_data.red;
    if (in_data.green < mn) mn = in_data.green;
    if (in_data.blue < mn) mn = in_data.blue;
  end

  // The middle channel is what remains of the sum.
  assign sum = {2'b00, in_data.red} + {2'b00, in_data.green} + {2'b00, in_data.blue};
  assign mid_wide = sum - {2'b00, mx} - {2'b00, mn};
  assign mid = mid_wide[CHAN_W-1:0];

  // Sector from the first matching (largest, smallest) pair.
  always_comb begin
    if (mx == in_data.red && mn == in_data.blue) begin
      sec = SEC_R_B;
    end else if (mx == in_data.green && mn == in_data.blue) begin
      sec = SEC_G_B;
    end else if (mx == in_data.green && mn == in_data.red) begin
      sec = SEC_G_R;
    end else if (mx == in_data.blue && mn == in_data.red) begin
      sec = SEC_B_R;
    end else if (mx == in_data.blue && mn == in_data.green) begin
      sec = SEC_B_G;
    end else begin
      sec = SEC_R_G;
    end
  end

  // Divider operands: (mid - min) over (max - min).
  always_comb begin
    data_next.value   = mx;
    data_next.sector  = sec;
    data_next.gray    = (mx == mn);
    data_next.tag     = in_data.tag;
    data_next.divisor = mx - mn;
    data_next.rem     = mid - mn;
    data_next.quo     = '0;
  end

  // Stage register; it moves whenever it is empty or its beat leaves.
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

`default_nettype wire

@@ design/rthv_div_stage.sv @@
// One divider stage: resolves STEPS quotient bits by restoring division.
// With LEAD set the first step compares the remainder unshifted, which
// gives the integer bit of the quotient. Depends on rthv_pkg.
`default_nettype none

module rthv_div_stage #(
  parameter int unsigned STEPS = rthv_pkg::DIV_STEPS,
  parameter bit          LEAD  = 1'b0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  rthv_pkg::work_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output rthv_pkg::work_t out_data
);
  import rthv_pkg::*;

  work_t data_next;

  // Shift, compare against the divisor, subtract when it fits.
  always_comb begin
    logic [CHAN_W:0]  trial;
    logic [CHAN_W-1:0] rem;
    logic [QUO_W-1:0]  quo;
    logic              fits;
    rem = in_data.rem;
    quo = in_data.quo;
    for (int i = 0; i < STEPS; i++) begin
      if (LEAD && i == 0) begin
        trial = {1'b0, rem};
      end else begin
        trial = {rem, 1'b0};
      end
      fits = (trial >= {1'b0, in_data.divisor});
      if (fits) begin
        trial = trial - {1'b0, in_data.divisor};
      end
      rem = trial[CHAN_W-1:0];
      quo = {quo[QUO_W-2:0], fits};
    end
    data_next     = in_data;
    data_next.rem = rem;
    data_next.quo = quo;
  end

  // Stage register with its valid bit.
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

`default_nettype wire

@@ design/rthv_hue.sv @@
// Last pipeline stage: turns sector and quotient into the hue and holds
// the result beat for the output channel. Depends on rthv_pkg.
`default_nettype none

module rthv_hue (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  rthv_pkg::work_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output rthv_pkg::result_t out_data
);
  import rthv_pkg::*;

  localparam logic [QUO_W-1:0] SECTOR_W = QUO_W'(HUE_SECTOR);

  logic [QUO_W-1:0] frac;
  logic [QUO_W-1:0] pos;
  logic [HUE_W-1:0] base;
  result_t          data_next;

  // Position in the sector, mirrored in the odd sectors.
  assign frac = in_data.quo + QUO_W'(1);
  assign pos  = in_data.sector[0] ? (SECTOR_W - frac) : frac;

  // sector * 65537 is the sector placed twice.
  assign base = {in_data.sector, FRAC_SHIFT'(0)} + HUE_W'(in_data.sector);

  always_comb begin
    data_next.value = in_data.value;
    data_next.tag   = in_data.tag;
    if (in_data.gray) begin
      data_next.hue = '0;
    end else begin
      data_next.hue = base + HUE_W'(pos);
    end
  end

  // Output register.
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

`default_nettype wire

@@ design/rgb_to_hue_value.sv @@
// Top level of the RGB to hue and value converter.
// Instantiates rthv_sort, rthv_div_stage and rthv_hue; uses rthv_pkg.
//
// The converter takes one pixel per clock while the output is not stalled and
// gives value (largest channel), hue (sector * 65537 + position, 0 for gray)
// and the tag. It is a six-stage pipeline: one stage sorts the channels, four
// stages run the restoring division of 17 quotient bits (five, then four at
// a time), and one stage forms the hue and serves as the output register.
// The sustained rate is one beat per cycle while out_ready is held high.
// Every stage holds its own valid bit and moves when it is empty or its beat
// moves on, so an output stall fills bubbles before input ready drops.
`default_nettype none

module rgb_to_hue_value (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rthv_pkg::CHAN_W-1:0]   red_in,
  input  logic [rthv_pkg::CHAN_W-1:0]   green_in,
  input  logic [rthv_pkg::CHAN_W-1:0]   blue_in,
  input  logic                          tag_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rthv_pkg::CHAN_W-1:0]   value_out,
  output logic [rthv_pkg::HUE_W-1:0]    hue_out,
  output logic                          tag_out
);
  import rthv_pkg::*;

  localparam int unsigned NDIV = 4;

  pixel_t  pix;
  work_t   work [NDIV+1];
  logic    vld  [NDIV+1];
  logic    rdy  [NDIV+1];
  result_t res;

  assign pix.red   = red_in;
  assign pix.green = green_in;
  assign pix.blue  = blue_in;
  assign pix.tag   = tag_in;

  // Channel sort and sector pick.
  rthv_sort u_sort (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (pix),
    .out_valid (vld[0]),
    .out_ready (rdy[0]),
    .out_data  (work[0])
  );

  // Divider stages; the first one also resolves the integer bit.
  for (genvar s = 0; s < NDIV; s++) begin : g_div
    rthv_div_stage #(
      .STEPS ((s == 0) ? DIV_STEPS_LEAD : DIV_STEPS),
      .LEAD  (s == 0)
    ) u_div (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (vld[s]),
      .in_ready  (rdy[s]),
      .in_data   (work[s]),
      .out_valid (vld[s+1]),
      .out_ready (rdy[s+1]),
      .out_data  (work[s+1])
    );
  end

  // Hue assembly and output register.
  rthv_hue u_hue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld[NDIV]),
    .in_ready  (rdy[NDIV]),
    .in_data   (work[NDIV]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (res)
  );

  assign value_out = res.value;
  assign hue_out   = res.hue;
  assign tag_out   = res.tag;

endmodule

`default_nettype wire

@@ design/rthv_checker.sv @@
// Port-level checks for rgb_to_hue_value, attached by the bind below.
// Depends on rthv_pkg.
`default_nettype none

module rthv_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_ready,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [rthv_pkg::CHAN_W-1:0] value_out,
  input  logic [rthv_pkg::HUE_W-1:0]  hue_out,
  input  logic                        tag_out
);
  import rthv_pkg::*;

  localparam logic [HUE_W-1:0] HUE_MAX = HUE_W'(6 * HUE_SECTOR - 1);

  // Reset leaves no result beat behind.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // An empty output register means the whole pipeline can advance.
  a_ready_when_drained: assert property (
    @(posedge clk) disable iff (rst) !out_valid |-> in_ready)
    else $error("input not ready while the output register is empty");

  // Hue stays on the circle.
  a_hue_range: assert property (
    @(posedge clk) disable iff (rst) out_valid |-> hue_out <= HUE_MAX)
    else $error("hue beyond the last sector");

  // A stalled result beat holds.
  a_out_hold: assert property (
    @(posedge clk) disable iff (rst) out_valid && !out_ready |=>
      out_valid && $stable(value_out) && $stable(hue_out) && $stable(tag_out))
    else $error("result beat changed while stalled");

endmodule

bind rgb_to_hue_value rthv_checker u_rthv_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .value_out (value_out),
  .hue_out   (hue_out),
  .tag_out   (tag_out)
);

`default_nettype wire
